// ===== sv/fpa_pkg.sv =====
// Package for the fixed-point ALU: widths, command codes and shared types.
package fpa_pkg;

   localparam int DataWidth = 32;
   localparam int CmdWidth = 4;
   localparam int FracBitsDefault = 8;
   localparam int QueueDepth = 2;

   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
      CMD_LT = 4'd4, CMD_LE = 4'd5, CMD_GT = 4'd6, CMD_GE = 4'd7,
      CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
      CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_FROM_INT = 4'd14, CMD_TO_INT = 4'd15
   } cmd_type;

   // Operation class chosen by the front end
   typedef enum logic [1:0] {
      CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
   } class_type;

   // Classified request handed from front to back
   typedef struct packed {
      class_type                   cls;
      logic                        div_zero;
      logic [DataWidth-1:0]        simple_result;
      logic                        simple_flag;
      logic                        a_neg;
      logic                        b_neg;
      logic                        res_neg;
      logic [DataWidth-1:0]        a_mag;
      logic [DataWidth-1:0]        b_mag;
   } work_type;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic                 flag;
      logic                 div_by_zero;
   } rsp_type;

endpackage

// ===== sv/fpa_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface fpa_req_if;
   logic                               valid;
   logic                               ready;
   logic [fpa_pkg::CmdWidth-1:0]       command;
   logic signed [fpa_pkg::DataWidth-1:0] operand_a;
   logic signed [fpa_pkg::DataWidth-1:0] operand_b;
   modport source (output valid, command, operand_a, operand_b, input ready);
   modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [fpa_pkg::DataWidth-1:0] result;
   logic                               flag;
   logic                               div_by_zero;
   modport source (output valid, result, flag, div_by_zero, input ready);
   modport sink (input valid, result, flag, div_by_zero, output ready);
endinterface

// ===== sv/fpa_front.sv =====
// Front end: accepts requests, evaluates the simple commands, classifies the rest.
module fpa_front #(
   parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   fpa_req_if.sink            req,
   output logic               work_valid,
   input  logic               work_ready,
   output fpa_pkg::work_type  work
);
   localparam int W = fpa_pkg::DataWidth;

   logic              valid_ff, valid_in;
   fpa_pkg::work_type work_ff, work_in;
   logic signed [W-1:0] a, b;
   logic [W-1:0] ua, ub, res;
   logic lt, gt, eq, flg;
   fpa_pkg::cmd_type cmd;

   assign a = req.operand_a;
   assign b = req.operand_b;
   assign ua = a;
   assign ub = b;
   assign cmd = fpa_pkg::cmd_type'(req.command);
   assign lt = a < b;
   assign gt = a > b;
   assign eq = a == b;

   // Evaluate the simple commands
   always_comb begin
      res = '0;
      flg = 1'b0;
      case (cmd)
         fpa_pkg::CMD_ADD:      res = ua + ub;
         fpa_pkg::CMD_SUB:      res = ua - ub;
         fpa_pkg::CMD_LT:       flg = lt;
         fpa_pkg::CMD_LE:       flg = lt | eq;
         fpa_pkg::CMD_GT:       flg = gt;
         fpa_pkg::CMD_GE:       flg = gt | eq;
         fpa_pkg::CMD_EQ:       flg = eq;
         fpa_pkg::CMD_NE:       flg = !eq;
         fpa_pkg::CMD_MIN:      res = lt ? ua : ub;
         fpa_pkg::CMD_MAX:      res = gt ? ua : ub;
         fpa_pkg::CMD_INC:      res = ua + W'(1);
         fpa_pkg::CMD_DEC:      res = ua - W'(1);
         fpa_pkg::CMD_FROM_INT: res = ua << FRAC_BITS;
         fpa_pkg::CMD_TO_INT:   res = W'(a >>> FRAC_BITS);
         default:               res = '0;
      endcase
   end

   // Classify and capture operand magnitudes
   always_comb begin
      work_in.cls = fpa_pkg::CLS_SIMPLE;
      if (cmd == fpa_pkg::CMD_MUL) work_in.cls = fpa_pkg::CLS_MUL;
      if (cmd == fpa_pkg::CMD_DIV) work_in.cls = fpa_pkg::CLS_DIV;
      work_in.div_zero = (cmd == fpa_pkg::CMD_DIV) && (ub == '0);
      work_in.simple_result = res;
      work_in.simple_flag = flg;
      work_in.a_neg = a[W-1];
      work_in.b_neg = b[W-1];
      work_in.res_neg = a[W-1] ^ b[W-1];
      work_in.a_mag = a[W-1] ? (~ua + W'(1)) : ua;
      work_in.b_mag = b[W-1] ? (~ub + W'(1)) : ub;
   end

   assign req.ready = !valid_ff || work_ready;
   assign valid_in = req.valid ? 1'b1 : (work_ready ? 1'b0 : valid_ff);

   // Hold the stage until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in && req.ready ? 1'b1 : (valid_ff && !work_ready);
      if (req.valid && req.ready) work_ff <= work_in;
   end

   assign work_valid = valid_ff;
   assign work = work_ff;
endmodule

// ===== sv/fpa_queue.sv =====
// Short FIFO that decouples the front end from the execution back end.
module fpa_queue #(
   parameter int DEPTH = fpa_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpa_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fpa_pkg::work_type out_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   fpa_pkg::work_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic push, pop;

   assign in_ready = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + AW'(1);
         if (pop) rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

// ===== sv/fpa_divider.sv =====
// Radix-2 restoring divider for the unsigned quotient of the divide command.
module fpa_divider #(
   parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fpa_pkg::DataWidth-1:0] num_mag,
   input  logic [fpa_pkg::DataWidth-1:0] den_mag,
   output logic                          busy,
   output logic                          done,
   output logic [fpa_pkg::DataWidth-1:0] quotient
);
   localparam int W = fpa_pkg::DataWidth;
   localparam int NW = W + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [W:0]    trial;
   logic [W:0]    diff;

   // One quotient bit per cycle, shifted into the numerator register
   always_comb begin
      trial = {rem_ff[W-1:0], num_ff[NW-1]};
      diff = trial - {1'b0, den_ff};
      num_in = {num_ff[NW-2:0], !diff[W]};
      rem_in = diff[W] ? trial : diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= NW'(num_mag) << FRAC_BITS;
         rem_ff <= '0;
         den_ff <= den_mag;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quotient = num_ff[W-1:0];
endmodule

// ===== sv/fpa_back.sv =====
// Back end: runs multiply and divide, selects results, holds the response register.
module fpa_back #(
   parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              work_valid,
   output logic              work_ready,
   input  fpa_pkg::work_type work,
   fpa_rsp_if.source         rsp
);
   localparam int W = fpa_pkg::DataWidth;

   logic   out_valid_ff;
   fpa_pkg::rsp_type out_ff;
   logic   mul_ff;
   logic   mul_neg_ff;
   logic [2*W-1:0] prod_ff;
   logic [2*W-1:0] shifted;
   logic   div_run_ff;
   logic   div_neg_ff;
   logic   out_free;
   logic   div_start, div_busy, div_done;
   logic [W-1:0] quot;
   logic   take;
   logic   is_div;

   assign out_free = !out_valid_ff || rsp.ready;
   assign is_div = (work.cls == fpa_pkg::CLS_DIV) && !work.div_zero;
   // Accept when the result path is free and nothing is in flight
   assign work_ready = out_free && !mul_ff && !div_run_ff;
   assign take = work_valid && work_ready;
   assign div_start = take && is_div;

   fpa_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num_mag(work.a_mag), .den_mag(work.b_mag),
      .busy(div_busy), .done(div_done), .quotient(quot)
   );

   assign shifted = prod_ff >> FRAC_BITS;

   // Sequence multiply, divide and simple results into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         mul_ff <= 1'b0;
         div_run_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) out_valid_ff <= 1'b0;
         if (mul_ff) begin
            mul_ff <= 1'b0;
            out_valid_ff <= 1'b1;
         end else if (div_done) begin
            div_run_ff <= 1'b0;
            out_valid_ff <= 1'b1;
         end else if (take) begin
            case (work.cls)
               fpa_pkg::CLS_MUL: mul_ff <= 1'b1;
               fpa_pkg::CLS_DIV: begin
                  if (is_div) div_run_ff <= 1'b1;
                  else out_valid_ff <= 1'b1;
               end
               default: out_valid_ff <= 1'b1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ff) begin
         out_ff.result <= mul_neg_ff ? (~shifted[W-1:0] + W'(1)) : shifted[W-1:0];
         out_ff.flag <= 1'b0;
         out_ff.div_by_zero <= 1'b0;
      end else if (div_done) begin
         out_ff.result <= div_neg_ff ? (~quot + W'(1)) : quot;
         out_ff.flag <= 1'b0;
         out_ff.div_by_zero <= 1'b0;
      end else if (take) begin
         prod_ff <= work.a_mag * work.b_mag;
         mul_neg_ff <= work.res_neg;
         div_neg_ff <= work.res_neg;
         out_ff.result <= work.div_zero ? '0 : work.simple_result;
         out_ff.flag <= work.simple_flag;
         out_ff.div_by_zero <= work.div_zero;
      end
   end

   assign rsp.valid = out_valid_ff && !div_busy && !mul_ff;
   assign rsp.result = out_ff.result;
   assign rsp.flag = out_ff.flag;
   assign rsp.div_by_zero = out_ff.div_by_zero;
endmodule

// ===== sv/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU.
//
// Requests arrive on req (command, operand_a, operand_b) and each gives one
// response on rsp (result, flag, div_by_zero), in request order.
// A front stage registers and classifies each request and evaluates add,
// subtract, comparisons, min/max, inc/dec and the conversions; a two-entry
// queue feeds the back end, which owns the response register.
// Simple commands: one per cycle while rsp is not stalled and no multiply or
// divide is in flight; each passes the front stage, the queue and the
// response register. Multiply: the 32x32 magnitude product is registered and
// the back end takes no further request until the scaled product is in the
// response register. Divide: the radix-2 divider forms one quotient bit per
// cycle and the quotient is then registered; the back end takes no further request while it runs.
// A divide with operand_b zero is answered at once with result 0 and
// div_by_zero set.
// Reset empties the front stage, queue and response register.
// When rsp is stalled the response is held; the queue and front stage keep
// accepting requests until they fill, then req.ready drops.
module fixed_point_alu #(
   parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
   input  logic      clock,
   input  logic      reset,
   fpa_req_if.sink   req,
   fpa_rsp_if.source rsp
);
   logic              f_valid, f_ready, q_valid, q_ready;
   fpa_pkg::work_type f_work, q_work;

   fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .req(req),
      .work_valid(f_valid), .work_ready(f_ready), .work(f_work)
   );

   fpa_queue #(.DEPTH(fpa_pkg::QueueDepth)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_work),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_work)
   );

   fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .work_valid(q_valid), .work_ready(q_ready), .work(q_work), .rsp(rsp)
   );
endmodule
